/* rtl/core/rhh_pkg.sv */
// shared types, codes and constants of the robin hood hash set engine
`timescale 1ns / 1ps

package rhh_pkg;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] key;
		logic [31:0] key_hash;
		logic [31:0] payload;
		logic [9:0]  slot_index;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_key;
		logic [31:0] found_value;
		logic        replaced;
		logic [9:0]  slot_out;
		logic [10:0] entry_total;
	} result_t;

	localparam logic [2:0] FN_LOOKUP = 3'd0;
	localparam logic [2:0] FN_SET    = 3'd1;
	localparam logic [2:0] FN_INSERT = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MISS    = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_HOME    = 4'd2;
	localparam logic [3:0] OP_FHIT    = 4'd3;
	localparam logic [3:0] OP_SETVAL  = 4'd4;
	localparam logic [3:0] OP_PEMPTY  = 4'd5;
	localparam logic [3:0] OP_PSWAP   = 4'd6;
	localparam logic [3:0] OP_NEXT    = 4'd7;
	localparam logic [3:0] OP_RHOLE   = 4'd8;
	localparam logic [3:0] OP_RSHIFT  = 4'd9;
	localparam logic [3:0] OP_REND    = 4'd10;
	localparam logic [3:0] OP_SREAD   = 4'd11;
	localparam logic [3:0] OP_CLRINIT = 4'd12;
	localparam logic [3:0] OP_CLRSTEP = 4'd13;

	localparam logic [9:0] LOAD_LIMIT_RST = 10'd768;

	typedef struct packed {
		logic [3:0] op;
		logic       st_we;
		logic [2:0] st;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic dist_zero;
		logic dist_le1;
		logic hit;
		logic rich;
		logic full;
		logic ptr_last;
	} sts_t;

endpackage

/* rtl/core/rhh_mod.sv */
// reduction of a 32-bit value modulo the slot count, iterative unless the count is a power of two
`timescale 1ns / 1ps

module rhh_mod #(
	parameter int SLOTS = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              value,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] res
);
	localparam int IW = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

	logic [31:0]   src_q;
	logic [IW-1:0] r_q;
	logic [5:0]    cnt_q;
	logic [IW:0]   r2;
	logic [IW-1:0] r_nxt;

	always_comb begin
		r2 = {r_q, src_q[31]};
		if (r2 >= (IW+1)'(SLOTS)) begin
			r_nxt = IW'(r2 - (IW+1)'(SLOTS));
		end else begin
			r_nxt = IW'(r2);
		end
	end

	// a power of two needs no iteration, so the source stays put for later reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= POW2 ? 6'd0 : 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q <= value;
			r_q   <= '0;
		end else if (cnt_q != '0) begin
			src_q <= {src_q[30:0], 1'b0};
			r_q   <= r_nxt;
		end
	end

	assign done = POW2 ? 1'b1 : (cnt_q == '0);
	assign res  = POW2 ? src_q[IW-1:0] : r_q;

endmodule

/* rtl/core/rhh_dp.sv */
// datapath: slot memory, probe pointer, carried entry and result registers
`timescale 1ns / 1ps

module rhh_dp import rhh_pkg::*; #(
	parameter int SLOTS     = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  item_t      item,
	input  logic [9:0] load_limit,
	output sts_t       sts,
	output result_t    result
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

	typedef struct packed {
		logic [31:0]   hash;
		logic [CW-1:0] pdist;
		logic [KW-1:0] key;
		logic [31:0]   value;
	} ent_t;

	ent_t mem [SLOTS];
	ent_t rd_q;
	ent_t cur_q;
	ent_t wdata;
	logic we;
	logic [IW-1:0] waddr;

	logic [IW-1:0] ptr_q, hole_q, first_q, ptr_inc;
	logic          landed_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   hash_q, val_q;
	logic [KW-1:0] key_q;

	logic [2:0]    status_q;
	logic [31:0]   fkey_q, fval_q;
	logic          repl_q;
	logic [IW-1:0] slot_q;

	logic          mod_start, mod_done;
	logic [IW-1:0] mod_res;

	assign mod_start = (cmd.op == OP_LOAD);

	rhh_mod #(.SLOTS(SLOTS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  ((item.func == FN_READ) ? 32'(item.slot_index) : item.key_hash),
		.done   (mod_done),
		.res    (mod_res)
	);

	assign ptr_inc = (ptr_q == IW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = cur_q;
		unique case (cmd.op) inside
			OP_SETVAL: begin
				we          = 1'b1;
				wdata       = rd_q;
				wdata.value = val_q;
			end
			OP_PEMPTY, OP_PSWAP: begin
				we = 1'b1;
			end
			OP_RSHIFT: begin
				we          = 1'b1;
				waddr       = hole_q;
				wdata       = rd_q;
				wdata.pdist = rd_q.pdist - 1'b1;
			end
			OP_REND: begin
				we    = 1'b1;
				waddr = hole_q;
				wdata = '0;
			end
			OP_CLRSTEP: begin
				we    = 1'b1;
				wdata = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[ptr_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			cnt_q    <= '0;
			landed_q <= 1'b0;
		end else begin
			unique case (cmd.op) inside
				OP_HOME: begin
					ptr_q    <= mod_res;
					landed_q <= 1'b0;
				end
				OP_PEMPTY: cnt_q <= cnt_q + 1'b1;
				OP_PSWAP: begin
					ptr_q    <= ptr_inc;
					landed_q <= 1'b1;
				end
				OP_NEXT, OP_RHOLE, OP_RSHIFT: ptr_q <= ptr_inc;
				OP_REND: cnt_q <= cnt_q - 1'b1;
				OP_CLRINIT: ptr_q <= '0;
				OP_CLRSTEP: begin
					ptr_q <= ptr_inc;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op) inside
			OP_LOAD, OP_CLRINIT: begin
				hash_q   <= item.key_hash;
				key_q    <= item.key[KW-1:0];
				val_q    <= item.payload;
				fkey_q   <= '0;
				fval_q   <= '0;
				repl_q   <= 1'b0;
				slot_q   <= '0;
			end
			OP_HOME: cur_q <= '{hash: hash_q, pdist: CW'(1), key: key_q, value: val_q};
			OP_FHIT: begin
				fkey_q <= 32'(rd_q.key);
				fval_q <= rd_q.value;
				slot_q <= ptr_q;
			end
			OP_SETVAL: repl_q <= 1'b1;
			OP_PEMPTY: slot_q <= landed_q ? first_q : ptr_q;
			OP_PSWAP: begin
				cur_q <= '{hash: rd_q.hash, pdist: rd_q.pdist + 1'b1, key: rd_q.key,
					value: rd_q.value};
				if (!landed_q) begin
					first_q <= ptr_q;
				end
			end
			OP_NEXT: cur_q.pdist <= cur_q.pdist + 1'b1;
			OP_RHOLE, OP_RSHIFT: hole_q <= ptr_q;
			OP_SREAD: begin
				slot_q <= ptr_q;
				if (rd_q.pdist != '0) begin
					fkey_q <= 32'(rd_q.key);
					fval_q <= rd_q.value;
				end
			end
			default: ;
		endcase
		if (cmd.st_we) begin
			status_q <= cmd.st;
		end else if (cmd.op == OP_LOAD || cmd.op == OP_CLRINIT) begin
			status_q <= ST_OK;
		end
	end

	always_comb begin
		sts.mod_done  = mod_done;
		sts.dist_zero = (rd_q.pdist == '0);
		sts.dist_le1  = (rd_q.pdist <= CW'(1));
		sts.hit       = (rd_q.hash == hash_q) && (rd_q.key == key_q);
		sts.rich      = (rd_q.pdist < cur_q.pdist);
		sts.full      = (32'(cnt_q) >= 32'(load_limit)) || (cnt_q >= CW'(SLOTS - 1));
		sts.ptr_last  = (ptr_q == IW'(SLOTS - 1));
	end

	always_comb begin
		result.status      = status_q;
		result.found_key   = fkey_q;
		result.found_value = fval_q;
		result.replaced    = repl_q;
		result.slot_out    = 10'(slot_q);
		result.entry_total = 11'(cnt_q);
	end

endmodule

/* rtl/core/rhh_ctrl.sv */
// controller state machine sequencing probes, shifts and clear sweeps
`timescale 1ns / 1ps

module rhh_ctrl import rhh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] func,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);
	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_MOD  = 4'd2;
	localparam logic [3:0] S_FW   = 4'd3;
	localparam logic [3:0] S_FE   = 4'd4;
	localparam logic [3:0] S_SETV = 4'd5;
	localparam logic [3:0] S_RH   = 4'd6;
	localparam logic [3:0] S_RW   = 4'd7;
	localparam logic [3:0] S_RE   = 4'd8;
	localparam logic [3:0] S_PW   = 4'd9;
	localparam logic [3:0] S_PE   = 4'd10;
	localparam logic [3:0] S_SW   = 4'd11;
	localparam logic [3:0] S_SE   = 4'd12;
	localparam logic [3:0] S_CLR  = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q, state_d;
	logic [2:0] func_q;

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NOP;
		cmd.st_we = 1'b0;
		cmd.st    = ST_OK;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_CLRSTEP;
				if (sts.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (func) inside
						FN_CLEAR: begin
							cmd.op  = OP_CLRINIT;
							state_d = S_CLR;
						end
						FN_LOOKUP, FN_SET, FN_INSERT, FN_REMOVE, FN_READ: begin
							cmd.op  = OP_LOAD;
							state_d = S_MOD;
						end
						default: begin
							cmd.op    = OP_LOAD;
							cmd.st_we = 1'b1;
							cmd.st    = ST_MISS;
							state_d   = S_DONE;
						end
					endcase
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.op  = OP_HOME;
					state_d = (func_q == FN_READ) ? S_SW : S_FW;
				end
			end
			S_FW: state_d = S_FE;
			S_FE: begin
				if (sts.dist_zero) begin
					if (func_q == FN_SET || func_q == FN_INSERT) begin
						if (sts.full) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_FULL;
							state_d   = S_DONE;
						end else begin
							// restart from home to place the new entry
							cmd.op  = OP_HOME;
							state_d = S_PW;
						end
					end else begin
						cmd.st_we = 1'b1;
						cmd.st    = ST_MISS;
						state_d   = S_DONE;
					end
				end else if (sts.hit) begin
					cmd.op = OP_FHIT;
					case (func_q)
						FN_SET:    state_d = S_SETV;
						FN_REMOVE: state_d = S_RH;
						FN_INSERT: begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_PRESENT;
							state_d   = S_DONE;
						end
						default:   state_d = S_DONE;
					endcase
				end else begin
					cmd.op  = OP_NEXT;
					state_d = S_FW;
				end
			end
			S_SETV: begin
				cmd.op  = OP_SETVAL;
				state_d = S_DONE;
			end
			S_RH: begin
				cmd.op  = OP_RHOLE;
				state_d = S_RW;
			end
			S_RW: state_d = S_RE;
			S_RE: begin
				if (sts.dist_le1) begin
					cmd.op  = OP_REND;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_RSHIFT;
					state_d = S_RW;
				end
			end
			S_PW: state_d = S_PE;
			S_PE: begin
				if (sts.dist_zero) begin
					cmd.op  = OP_PEMPTY;
					state_d = S_DONE;
				end else if (sts.rich) begin
					cmd.op  = OP_PSWAP;
					state_d = S_PW;
				end else begin
					cmd.op  = OP_NEXT;
					state_d = S_PW;
				end
			end
			S_SW: state_d = S_SE;
			S_SE: begin
				cmd.op    = OP_SREAD;
				cmd.st_we = 1'b1;
				cmd.st    = sts.dist_zero ? ST_EMPTY : ST_OK;
				state_d   = S_DONE;
			end
			S_CLR: begin
				cmd.op = OP_CLRSTEP;
				if (sts.ptr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			func_q  <= FN_LOOKUP;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				func_q <= func;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

/* rtl/core/robin_hood_hash_set_engine.sv */
// top level: robin hood hash set with backward-shift deletion and apb register
//
//   port group      direction  handshake            contents
//   item            in         start & !busy        func, key, key_hash, payload, slot_index
//   result          out        done, one cycle      status, found_key/value, replaced, ...
//   apb             in/out     psel penable pready  load_limit at byte address 0
//
// an item takes setup steps, then a read wait and a compare for each probed or shifted
// slot; a replace or a remove adds one more step; the home slot reduction needs no
// iteration when SLOTS is a power of two, else it runs bit by bit over the 32-bit value
// clear and the pass after reset sweep the slot memory with busy held high
// the slot memory with one write port and a registered read sets the probe step: a read wait, then the compare
// results cannot be stalled: done is high for one cycle per item
`timescale 1ns / 1ps

module robin_hood_hash_set_engine import rhh_pkg::*; #(
	parameter int SLOTS     = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [9:0] load_limit_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LOAD_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			load_limit_q <= pwdata[9:0];
		end
	end

	assign prdata = paddr[2] ? '0 : 32'(load_limit_q);

	rhh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rhh_dp #(
		.SLOTS     (SLOTS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.load_limit (load_limit_q),
		.sts        (sts),
		.result     (result)
	);

endmodule
